// ===== sv/cau_pkg.sv =====
package cau_pkg;

	// Operation codes carried on the action field
	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

endpackage

// ===== sv/complex_arith_unit_top.sv =====
// Channel   Handshake              Word
// -------   --------------------   ---------------------------------------------
// in        in_valid / in_stall    action, a_re, a_im, b_re, b_im
// out       out_valid / out_stall  res_re, res_im, overflow, div_by_zero
//
// One word enters per cycle while in_stall is low. Every operation has the same
// depth: four front stages, one divider stage per quotient bit
// (DATA_WIDTH + 1 of them) and the output register. The restoring divider
// sets the depth. Reset clears only the valid bits. A stall on a waiting
// output word holds the whole pipeline and raises in_stall in the same cycle.
module complex_arith_unit_top #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         overflow,
	output logic                         div_by_zero
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int DW = 2 * W;
	localparam int XW = 2 * W + F;
	localparam int QB = W + 1;

	localparam logic signed [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MAXNEG = {1'b1, {(W-1){1'b0}}};

	logic en;

	// Hold everything while the output word waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: capture operands
	logic                 v_s1;
	cau_pkg::action_t     act_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= cau_pkg::action_t'(action);
			ar_s1  <= a_re;
			ai_s1  <= a_im;
			br_s1  <= b_re;
			bi_s1  <= b_im;
		end
	end

	// Stage 2: partial products and add/subtract
	logic                 v_s2;
	cau_pkg::action_t     act_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_bb_s2, p_cc_s2;
	logic signed [W:0]    as_re_s2, as_im_s2;
	logic signed [W:0]    as_re_d, as_im_d;

	always_comb begin
		if (act_s1 == cau_pkg::ACT_SUB) begin
			as_re_d = (W+1)'(ar_s1) - (W+1)'(br_s1);
			as_im_d = (W+1)'(ai_s1) - (W+1)'(bi_s1);
		end else begin
			as_re_d = (W+1)'(ar_s1) + (W+1)'(br_s1);
			as_im_d = (W+1)'(ai_s1) + (W+1)'(bi_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2   <= act_s1;
			p_rr_s2  <= PW'(ar_s1) * PW'(br_s1);
			p_ii_s2  <= PW'(ai_s1) * PW'(bi_s1);
			p_ri_s2  <= PW'(ar_s1) * PW'(bi_s1);
			p_ir_s2  <= PW'(ai_s1) * PW'(br_s1);
			p_bb_s2  <= PW'(br_s1) * PW'(br_s1);
			p_cc_s2  <= PW'(bi_s1) * PW'(bi_s1);
			as_re_s2 <= as_re_d;
			as_im_s2 <= as_im_d;
		end
	end

	// Stage 3: product sums and divisor
	logic                 v_s3;
	cau_pkg::action_t     act_s3;
	logic signed [SW-1:0] mre_s3, mim_s3, nre_s3, nim_s3;
	logic [DW-1:0]        den_s3;
	logic signed [W:0]    as_re_s3, as_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s3   <= act_s2;
			mre_s3   <= SW'(p_rr_s2) - SW'(p_ii_s2);
			mim_s3   <= SW'(p_ri_s2) + SW'(p_ir_s2);
			nre_s3   <= SW'(p_rr_s2) + SW'(p_ii_s2);
			nim_s3   <= SW'(p_ir_s2) - SW'(p_ri_s2);
			den_s3   <= DW'(p_bb_s2) + DW'(p_cc_s2);
			as_re_s3 <= as_re_s2;
			as_im_s3 <= as_im_s2;
		end
	end

	// Stage 4 logic: finish add/sub/mul, set up the divider
	logic signed [SW-1:0] sh_re, sh_im;
	logic signed [W-1:0]  fr_re, fr_im;
	logic                 fovf;
	logic                 neg_re, neg_im;
	logic [DW-1:0]        mag_re, mag_im;
	logic [XW-1:0]        dvd_re, dvd_im, top_re, top_im;
	logic                 big_re, big_im;

	always_comb begin
		sh_re = mre_s3 >>> F;
		sh_im = mim_s3 >>> F;
		fovf  = 1'b0;
		fr_re = '0;
		fr_im = '0;
		if (act_s3 == cau_pkg::ACT_MUL) begin
			if (sh_re[SW-1:W-1] != '0 && sh_re[SW-1:W-1] != '1) begin
				fr_re = sh_re[SW-1] ? MAXNEG : MAXPOS;
				fovf  = 1'b1;
			end else begin
				fr_re = sh_re[W-1:0];
			end
			if (sh_im[SW-1:W-1] != '0 && sh_im[SW-1:W-1] != '1) begin
				fr_im = sh_im[SW-1] ? MAXNEG : MAXPOS;
				fovf  = 1'b1;
			end else begin
				fr_im = sh_im[W-1:0];
			end
		end else begin
			if (as_re_s3[W] != as_re_s3[W-1]) begin
				fr_re = as_re_s3[W] ? MAXNEG : MAXPOS;
				fovf  = 1'b1;
			end else begin
				fr_re = as_re_s3[W-1:0];
			end
			if (as_im_s3[W] != as_im_s3[W-1]) begin
				fr_im = as_im_s3[W] ? MAXNEG : MAXPOS;
				fovf  = 1'b1;
			end else begin
				fr_im = as_im_s3[W-1:0];
			end
		end

		neg_re = nre_s3[SW-1];
		neg_im = nim_s3[SW-1];
		mag_re = neg_re ? DW'(-nre_s3) : DW'(nre_s3);
		mag_im = neg_im ? DW'(-nim_s3) : DW'(nim_s3);
		dvd_re = XW'(mag_re) << F;
		dvd_im = XW'(mag_im) << F;
		top_re = dvd_re >> QB;
		top_im = dvd_im >> QB;
		big_re = top_re >= XW'(den_s3);
		big_im = top_im >= XW'(den_s3);
	end

	// Divider chain; index 0 is stage 4, index k is stage 4 + k
	logic                 v_sd     [0:QB];
	logic                 div_sd   [0:QB];
	logic                 dz_sd    [0:QB];
	logic signed [W-1:0]  fre_sd   [0:QB];
	logic signed [W-1:0]  fim_sd   [0:QB];
	logic                 fovf_sd  [0:QB];
	logic                 nre_sd   [0:QB];
	logic                 nim_sd   [0:QB];
	logic                 bre_sd   [0:QB];
	logic                 bim_sd   [0:QB];
	logic [DW-1:0]        den_sd   [0:QB];
	logic [DW-1:0]        rre_sd   [0:QB];
	logic [DW-1:0]        rim_sd   [0:QB];
	logic [QB-1:0]        qre_sd   [0:QB];
	logic [QB-1:0]        qim_sd   [0:QB];
	logic [QB-1:0]        lre_sd   [0:QB];
	logic [QB-1:0]        lim_sd   [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_sd[0]  <= act_s3 == cau_pkg::ACT_DIV;
			dz_sd[0]   <= den_s3 == '0;
			fre_sd[0]  <= fr_re;
			fim_sd[0]  <= fr_im;
			fovf_sd[0] <= fovf;
			nre_sd[0]  <= neg_re;
			nim_sd[0]  <= neg_im;
			bre_sd[0]  <= big_re;
			bim_sd[0]  <= big_im;
			den_sd[0]  <= den_s3;
			rre_sd[0]  <= top_re[DW-1:0];
			rim_sd[0]  <= top_im[DW-1:0];
			qre_sd[0]  <= '0;
			qim_sd[0]  <= '0;
			lre_sd[0]  <= dvd_re[QB-1:0];
			lim_sd[0]  <= dvd_im[QB-1:0];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DW:0] t_re, t_im;
		logic        ge_re, ge_im;

		// Shift in the next dividend bit, subtract where it fits
		always_comb begin
			t_re  = {rre_sd[k], lre_sd[k][QB-1]};
			t_im  = {rim_sd[k], lim_sd[k][QB-1]};
			ge_re = t_re >= {1'b0, den_sd[k]};
			ge_im = t_im >= {1'b0, den_sd[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_sd[k+1]  <= div_sd[k];
				dz_sd[k+1]   <= dz_sd[k];
				fre_sd[k+1]  <= fre_sd[k];
				fim_sd[k+1]  <= fim_sd[k];
				fovf_sd[k+1] <= fovf_sd[k];
				nre_sd[k+1]  <= nre_sd[k];
				nim_sd[k+1]  <= nim_sd[k];
				bre_sd[k+1]  <= bre_sd[k];
				bim_sd[k+1]  <= bim_sd[k];
				den_sd[k+1]  <= den_sd[k];
				rre_sd[k+1]  <= ge_re ? DW'(t_re - (DW+1)'(den_sd[k])) : t_re[DW-1:0];
				rim_sd[k+1]  <= ge_im ? DW'(t_im - (DW+1)'(den_sd[k])) : t_im[DW-1:0];
				qre_sd[k+1]  <= {qre_sd[k][QB-2:0], ge_re};
				qim_sd[k+1]  <= {qim_sd[k][QB-2:0], ge_im};
				lre_sd[k+1]  <= {lre_sd[k][QB-2:0], 1'b0};
				lim_sd[k+1]  <= {lim_sd[k][QB-2:0], 1'b0};
			end
		end
	end

	// Output stage: sign and saturate the quotients, pick the result
	logic [QB-1:0]       qr, qi;
	logic signed [W-1:0] o_re, o_im;
	logic                o_ovf, o_dz;

	always_comb begin
		qr    = qre_sd[QB];
		qi    = qim_sd[QB];
		o_re  = fre_sd[QB];
		o_im  = fim_sd[QB];
		o_ovf = fovf_sd[QB];
		o_dz  = 1'b0;
		if (div_sd[QB]) begin
			o_ovf = 1'b0;
			if (dz_sd[QB]) begin
				o_re = '0;
				o_im = '0;
				o_dz = 1'b1;
			end else begin
				if (!nre_sd[QB]) begin
					if (bre_sd[QB] || qr[QB-1:W-1] != '0) begin
						o_re  = MAXPOS;
						o_ovf = 1'b1;
					end else begin
						o_re = qr[W-1:0];
					end
				end else begin
					if (bre_sd[QB] || qr[QB-1] || (qr[W-1] && qr[W-2:0] != '0)) begin
						o_re  = MAXNEG;
						o_ovf = 1'b1;
					end else begin
						o_re = -qr[W-1:0];
					end
				end
				if (!nim_sd[QB]) begin
					if (bim_sd[QB] || qi[QB-1:W-1] != '0) begin
						o_im  = MAXPOS;
						o_ovf = 1'b1;
					end else begin
						o_im = qi[W-1:0];
					end
				end else begin
					if (bim_sd[QB] || qi[QB-1] || (qi[W-1] && qi[W-2:0] != '0)) begin
						o_im  = MAXNEG;
						o_ovf = 1'b1;
					end else begin
						o_im = -qi[W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_sd[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re      <= o_re;
			res_im      <= o_im;
			overflow    <= o_ovf;
			div_by_zero <= o_dz;
		end
	end

endmodule

// ===== sv/cau_checker.sv =====
module cau_checker #(
	parameter int DATA_WIDTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [DATA_WIDTH-1:0] res_re,
	input logic signed [DATA_WIDTH-1:0] res_im,
	input logic                         overflow,
	input logic                         div_by_zero
);

	localparam logic signed [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MAXNEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// A stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_re) && $stable(res_im)
			&& $stable(overflow) && $stable(div_by_zero))
		else $error("stalled output word changed");

	// Input is held off only behind a waiting output word
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without a waiting output word");

	// A zero divisor gives a clean zero
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("divide by zero result not zero");

	// Overflow always shows a saturated part
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> res_re == MAXPOS || res_re == MAXNEG
			|| res_im == MAXPOS || res_im == MAXNEG)
		else $error("overflow without a saturated part");

endmodule

bind complex_arith_unit_top cau_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.res_re     (res_re),
	.res_im     (res_im),
	.overflow   (overflow),
	.div_by_zero(div_by_zero)
);
